/* rtl/tlsw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsw_pkg: shared types and constants of the sequence window engine
// Request, status and frame codes, register indexes and the payload structs
// used by the channels and the engine.
// ----------------------------------------------------------------------------
package tlsw_pkg;

    localparam int SEQ_W          = 15;
    localparam int CFG_DATA_W     = 15;
    localparam int CFG_INDEX_W    = 2;
    localparam int NUM_TIMERS     = 5;
    localparam int TIMER_BITS_DEF = 16;
    localparam int CTRL_W         = 32;

    localparam logic [SEQ_W:0]   SEQ_MOD     = 16'd32768;
    localparam logic [SEQ_W-1:0] SEQ_MAX     = '1;
    localparam logic [15:0]      S_FRAME_LOW = 16'h0001;

    // Elapsed-second timer slots.
    localparam int TM_ISEND    = 0;
    localparam int TM_TESTSEND = 1;
    localparam int TM_RECV     = 2;
    localparam int TM_TESTCON  = 3;
    localparam int TM_ACK      = 4;

    localparam logic [7:0]       ACK_TIMEOUT_RST  = 8'd30;
    localparam logic [7:0]       IDLE_TIMEOUT_RST = 8'd8;
    localparam logic [SEQ_W-1:0] WINDOW_SIZE_RST  = 15'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACK_TIMEOUT  = 2'd0,
        CFG_IDLE_TIMEOUT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2,
        CFG_TEST_ONLY    = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        REQ_START      = 4'd0,
        REQ_STOP       = 4'd1,
        REQ_FRAME_RECV = 4'd2,
        REQ_I_SENT     = 4'd3,
        REQ_ANY_RECV   = 4'd4,
        REQ_TEST_SENT  = 4'd5,
        REQ_TEST_CONF  = 4'd6,
        REQ_RESYNC     = 4'd7,
        REQ_FILL       = 4'd8,
        REQ_TICK       = 4'd9,
        REQ_ISEND_TIME = 4'd10,
        REQ_ACK_TIME   = 4'd11
    } req_code_t;

    typedef enum logic [2:0] {
        ST_NORMAL      = 3'd0,
        ST_NOT_STARTED = 3'd1,
        ST_T1_TIMEOUT  = 3'd2,
        ST_T3_TIMEOUT  = 3'd3,
        ST_WINDOW_FULL = 3'd4,
        ST_BAD_KIND    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_I       = 2'd0,
        KIND_S       = 2'd1,
        KIND_U       = 2'd2,
        KIND_INVALID = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic [7:0]       ack_timeout_seconds;
        logic [7:0]       idle_timeout_seconds;
        logic [SEQ_W-1:0] window_size;
        logic             test_only_mode;
    } cfg_t;

    typedef struct packed {
        logic [3:0]       req_type;
        logic [SEQ_W-1:0] peer_send_number;
        logic [SEQ_W-1:0] peer_recv_number;
        logic [1:0]       frame_kind;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CTRL_W-1:0] control_word;
        logic              control_valid;
        logic [SEQ_W-1:0]  send_number;
        logic [SEQ_W-1:0]  recv_number;
        logic [SEQ_W-1:0]  unacked_count;
        logic              window_reopened;
    } rsp_t;

endpackage
`default_nettype wire

/* rtl/tlsw_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsw_if: request and response channels
// Valid/ready channels carrying one link event in and one result out.
// ----------------------------------------------------------------------------
interface tlsw_req_if
    import tlsw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [3:0]       req_type;
    logic [SEQ_W-1:0] peer_send_number;
    logic [SEQ_W-1:0] peer_recv_number;
    logic [1:0]       frame_kind;

    modport source (output valid, req_type, peer_send_number, peer_recv_number,
                    frame_kind, input ready);
    modport sink   (input valid, req_type, peer_send_number, peer_recv_number,
                    frame_kind, output ready);
endinterface

interface tlsw_rsp_if
    import tlsw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [CTRL_W-1:0] control_word;
    logic              control_valid;
    logic [SEQ_W-1:0]  send_number;
    logic [SEQ_W-1:0]  recv_number;
    logic [SEQ_W-1:0]  unacked_count;
    logic              window_reopened;

    modport source (output valid, status, control_word, control_valid, send_number,
                    recv_number, unacked_count, window_reopened, input ready);
    modport sink   (input valid, status, control_word, control_valid, send_number,
                    recv_number, unacked_count, window_reopened, output ready);
endinterface
`default_nettype wire

/* rtl/telecontrol_link_sequence_window_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telecontrol_link_sequence_window_top: 15-bit link sequence window engine
// Tracks send/receive numbers, the unacknowledged count against window k,
// elapsed-second timers and t1/t3 timeouts, and builds I/S control bytes.
//
// Usage:
//   - req carries one link event per transfer; rsp returns exactly one
//     result per event, in order.
//   - Configuration registers are written through cfg_we/cfg_index/cfg_data
//     while no event is in flight.
//   - An event is captured in an input register, evaluated by one pass of
//     compare/add logic against the link state, and its result is loaded
//     into the output register, from which it is offered on rsp.
//   - Throughput is one event per cycle unless rsp stalls; the input register
//     accepts a new event while a result waits in the output register.
//   - When rsp is stalled, the output register holds its result and the
//     input register holds one more event; req.ready then drops.
//   - Reset clears both stages and returns the registers and the link
//     state to their defaults (link stopped, window 12, t1 30 s, t3 8 s).
// ----------------------------------------------------------------------------
module telecontrol_link_sequence_window_top
    import tlsw_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    tlsw_req_if.sink                    req,
    tlsw_rsp_if.source                  rsp
);

    cfg_t cfg;
    req_t in_data_reg;
    logic in_valid_reg, in_valid_next;
    rsp_t out_data_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t step_rsp;
    logic advance, in_take;

    tlsw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlsw_seq_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (in_data_reg),
        .cfg     (cfg),
        .rsp     (step_rsp)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.req_type         <= req.req_type;
            in_data_reg.peer_send_number <= req.peer_send_number;
            in_data_reg.peer_recv_number <= req.peer_recv_number;
            in_data_reg.frame_kind       <= req.frame_kind;
        end
        if (advance)
            out_data_reg <= step_rsp;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_data_reg.status;
    assign rsp.control_word    = out_data_reg.control_word;
    assign rsp.control_valid   = out_data_reg.control_valid;
    assign rsp.send_number     = out_data_reg.send_number;
    assign rsp.recv_number     = out_data_reg.recv_number;
    assign rsp.unacked_count   = out_data_reg.unacked_count;
    assign rsp.window_reopened = out_data_reg.window_reopened;

endmodule
`default_nettype wire

/* rtl/tlsw_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsw_cfg_regs: configuration registers
// Holds t1, t3, window size k and the test-only mode flag.
// ----------------------------------------------------------------------------
module tlsw_cfg_regs
    import tlsw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout_seconds  <= ACK_TIMEOUT_RST;
            cfg_reg.idle_timeout_seconds <= IDLE_TIMEOUT_RST;
            cfg_reg.window_size          <= WINDOW_SIZE_RST;
            cfg_reg.test_only_mode       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACK_TIMEOUT:  cfg_reg.ack_timeout_seconds  <= cfg_data[7:0];
                CFG_IDLE_TIMEOUT: cfg_reg.idle_timeout_seconds <= cfg_data[7:0];
                CFG_WINDOW_SIZE:  cfg_reg.window_size          <= cfg_data[SEQ_W-1:0];
                CFG_TEST_ONLY:    cfg_reg.test_only_mode       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* rtl/tlsw_seq_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsw_seq_engine: link state and per-event update
// Holds the sequence numbers, unacknowledged count and elapsed timers, and
// computes the result of one event from the registered request.
// ----------------------------------------------------------------------------
module tlsw_seq_engine
    import tlsw_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step_en,
    input  req_t      req,
    input  cfg_t      cfg,
    output rsp_t      rsp
);

    typedef logic [TIMER_BITS-1:0] timer_t;

    logic             started_reg, started_next;
    logic             resync_reg, resync_next;
    logic [SEQ_W-1:0] send_reg, send_next;
    logic [SEQ_W-1:0] recv_reg, recv_next;
    logic [SEQ_W-1:0] last_reg, last_next;
    logic [SEQ_W-1:0] unacked_reg, unacked_next;
    logic             test_conf_reg, test_conf_next;
    timer_t           timer_reg [NUM_TIMERS];
    timer_t           timer_next [NUM_TIMERS];
    timer_t           timer_inc [NUM_TIMERS];

    // Received-frame path: state after a pending resync is applied.
    logic [SEQ_W-1:0] nr, ns_peer;
    logic [SEQ_W-1:0] send0, recv0, last0, cnt0;
    logic [SEQ_W:0]   last_plus_cnt, sub_fwd, sub_wrap, sub_sel;
    logic [SEQ_W+1:0] cnt_diff;
    logic             in_window, nr_gt_ns, nr_lt_last, use_wrap, force_zero;
    logic [SEQ_W-1:0] rx_cnt, rx_send, rx_recv;
    logic             was_full, rx_reopened;

    timer_t           t1_th, t3_th;
    status_t          tick_status;
    status_t          status;
    logic [CTRL_W-1:0] word;
    logic             word_valid, reopened;

    assign nr      = req.peer_recv_number;
    assign ns_peer = req.peer_send_number;
    assign send0   = resync_reg ? nr      : send_reg;
    assign recv0   = resync_reg ? ns_peer : recv_reg;
    assign last0   = resync_reg ? nr      : last_reg;
    assign cnt0    = resync_reg ? '0      : unacked_reg;

    assign was_full      = (cnt0 == cfg.window_size);
    assign rx_recv       = (frame_kind_t'(req.frame_kind) == KIND_I) ? recv0 + 1'b1 : recv0;
    assign last_plus_cnt = {1'b0, last0} + {1'b0, cnt0};
    assign nr_gt_ns      = (nr > send0);
    assign nr_lt_last    = (nr < last0);
    assign in_window     = !nr_lt_last && ({1'b0, nr} <= last_plus_cnt);
    assign sub_fwd       = {1'b0, nr} - {1'b0, last0};
    assign sub_wrap      = SEQ_MOD - {1'b0, last0} + {1'b0, nr};

    // A peer number outside the outstanding range resequences our send number.
    always_comb
    begin
        use_wrap   = 1'b0;
        force_zero = 1'b0;
        if (nr_gt_ns)
        begin
            force_zero = !in_window;
        end
        else if (nr_lt_last)
        begin
            if (nr < cnt0)
                use_wrap = 1'b1;
            else
                force_zero = 1'b1;
        end
    end

    assign sub_sel  = use_wrap ? sub_wrap : sub_fwd;
    assign cnt_diff = {2'b00, cnt0} - {1'b0, sub_sel};
    assign rx_cnt   = (force_zero || cnt_diff[SEQ_W+1]) ? '0 : cnt_diff[SEQ_W-1:0];
    assign rx_send  = force_zero ? nr : send0;
    assign rx_reopened = was_full && (rx_cnt < cfg.window_size);

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
            timer_inc[i] = (timer_reg[i] == '1) ? timer_reg[i] : timer_reg[i] + 1'b1;
    end

    assign t1_th = TIMER_BITS'(cfg.ack_timeout_seconds);
    assign t3_th = TIMER_BITS'(cfg.idle_timeout_seconds);

    // Timeout checks see the timers after this tick's advance.
    always_comb
    begin
        tick_status = ST_NORMAL;
        if (!cfg.test_only_mode && unacked_reg != '0)
        begin
            if (timer_inc[TM_ISEND] >= t1_th && timer_inc[TM_ACK] >= t1_th)
                tick_status = ST_T1_TIMEOUT;
        end
        else if (!test_conf_reg)
        begin
            if (timer_inc[TM_TESTSEND] >= t1_th && timer_inc[TM_TESTCON] >= t1_th)
                tick_status = ST_T1_TIMEOUT;
        end
        else if (cfg.test_only_mode)
        begin
            if (timer_inc[TM_TESTSEND] >= t3_th)
                tick_status = ST_T3_TIMEOUT;
        end
        else if (timer_inc[TM_RECV] >= t3_th)
        begin
            tick_status = ST_T3_TIMEOUT;
        end
    end

    always_comb
    begin
        started_next   = started_reg;
        resync_next    = resync_reg;
        send_next      = send_reg;
        recv_next      = recv_reg;
        last_next      = last_reg;
        unacked_next   = unacked_reg;
        test_conf_next = test_conf_reg;
        for (int i = 0; i < NUM_TIMERS; i++)
            timer_next[i] = timer_reg[i];
        status     = ST_NORMAL;
        word       = '0;
        word_valid = 1'b0;
        reopened   = 1'b0;

        if (req_code_t'(req.req_type) == REQ_START)
        begin
            started_next   = 1'b1;
            resync_next    = 1'b0;
            send_next      = '0;
            recv_next      = '0;
            last_next      = '0;
            unacked_next   = '0;
            test_conf_next = 1'b1;
            for (int i = 0; i < NUM_TIMERS; i++)
                timer_next[i] = '0;
        end
        else if (req_code_t'(req.req_type) == REQ_STOP)
        begin
            started_next = 1'b0;
            resync_next  = 1'b0;
        end
        else if (req.req_type inside {[4'd12:4'd15]})
        begin
            status = ST_NORMAL;
        end
        else if (!started_reg)
        begin
            status = ST_NOT_STARTED;
        end
        else
        begin
            case (req_code_t'(req.req_type))
                REQ_FRAME_RECV:
                begin
                    resync_next          = 1'b0;
                    recv_next            = rx_recv;
                    send_next            = rx_send;
                    unacked_next         = rx_cnt;
                    last_next            = nr;
                    timer_next[TM_ACK]   = '0;
                    timer_next[TM_RECV]  = '0;
                    reopened             = rx_reopened;
                end
                REQ_I_SENT:
                begin
                    send_next           = send_reg + 1'b1;
                    timer_next[TM_ISEND] = '0;
                    unacked_next        = (unacked_reg == SEQ_MAX) ? SEQ_MAX
                                                                   : unacked_reg + 1'b1;
                end
                REQ_ANY_RECV:
                begin
                    timer_next[TM_RECV] = '0;
                end
                REQ_TEST_SENT:
                begin
                    timer_next[TM_TESTSEND] = '0;
                    test_conf_next          = 1'b0;
                end
                REQ_TEST_CONF:
                begin
                    test_conf_next         = 1'b1;
                    timer_next[TM_TESTCON] = '0;
                    timer_next[TM_RECV]    = '0;
                end
                REQ_RESYNC:
                begin
                    resync_next = 1'b1;
                end
                REQ_FILL:
                begin
                    if (unacked_reg >= cfg.window_size)
                        status = ST_WINDOW_FULL;
                    else
                    begin
                        case (frame_kind_t'(req.frame_kind))
                            KIND_I:
                            begin
                                word       = {recv_reg, 1'b0, send_reg, 1'b0};
                                word_valid = 1'b1;
                            end
                            KIND_S:
                            begin
                                word       = {recv_reg, 1'b0, S_FRAME_LOW};
                                word_valid = 1'b1;
                            end
                            KIND_INVALID: status = ST_BAD_KIND;
                            default:      status = ST_NORMAL;
                        endcase
                    end
                end
                REQ_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                        timer_next[i] = timer_inc[i];
                    status = tick_status;
                end
                REQ_ISEND_TIME:
                begin
                    timer_next[TM_ISEND] = '0;
                end
                REQ_ACK_TIME:
                begin
                    timer_next[TM_ACK] = '0;
                end
                default:
                begin
                    status = ST_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            resync_reg    <= 1'b0;
            send_reg      <= '0;
            recv_reg      <= '0;
            last_reg      <= '0;
            unacked_reg   <= '0;
            test_conf_reg <= 1'b1;
            for (int i = 0; i < NUM_TIMERS; i++)
                timer_reg[i] <= '0;
        end
        else if (step_en)
        begin
            started_reg   <= started_next;
            resync_reg    <= resync_next;
            send_reg      <= send_next;
            recv_reg      <= recv_next;
            last_reg      <= last_next;
            unacked_reg   <= unacked_next;
            test_conf_reg <= test_conf_next;
            for (int i = 0; i < NUM_TIMERS; i++)
                timer_reg[i] <= timer_next[i];
        end
    end

    assign rsp.status          = status;
    assign rsp.control_word    = word;
    assign rsp.control_valid   = word_valid;
    assign rsp.send_number     = send_next;
    assign rsp.recv_number     = recv_next;
    assign rsp.unacked_count   = unacked_next;
    assign rsp.window_reopened = reopened;

endmodule
`default_nettype wire

/* rtl/tlsw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsw_checker: port-level checks of the sequence window engine
// Watches the response channel for handshake and control-byte consistency.
// ----------------------------------------------------------------------------
module tlsw_checker
    import tlsw_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [2:0]        rsp_status,
    input wire logic [CTRL_W-1:0] rsp_control_word,
    input wire logic              rsp_control_valid,
    input wire logic [SEQ_W-1:0]  rsp_send_number,
    input wire logic [SEQ_W-1:0]  rsp_recv_number,
    input wire logic              rsp_window_reopened
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Control bytes only come from a successful fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_control_valid |->
            rsp_status == ST_NORMAL && !rsp_window_reopened)
        else $error("control bytes with non-normal status or reopen flag");

    // The receive number in bits 31:17 matches the reported receive number.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_control_valid |->
            !rsp_control_word[16] && rsp_control_word[31:17] == rsp_recv_number)
        else $error("control word receive number mismatch");

    // An I format word carries the current send number in bits 15:1.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_control_valid && !rsp_control_word[0] |->
            rsp_control_word[15:1] == rsp_send_number)
        else $error("control word send number mismatch");

endmodule

bind telecontrol_link_sequence_window_top tlsw_checker u_tlsw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_control_word    (rsp.control_word),
    .rsp_control_valid   (rsp.control_valid),
    .rsp_send_number     (rsp.send_number),
    .rsp_recv_number     (rsp.recv_number),
    .rsp_window_reopened (rsp.window_reopened)
);
`default_nettype wire
